@@ design/tapid_pkg.sv @@
// ----------------------------------------------------------------------------
// tapid_pkg
// Shared types and constants for the three-axis attitude PID block.
// ----------------------------------------------------------------------------
package tapid_pkg;

  // Gain word: three unsigned gains packed as P[47:32] I[31:16] D[15:0]
  localparam int GAIN_W     = 16;
  localparam int GAINS_W    = 3 * GAIN_W;
  localparam int CFG_DATA_W = GAINS_W;
  localparam int CFG_IDX_W  = 3;

  // Parameter defaults
  localparam int ANGLE_WIDTH_DEF        = 20;
  localparam int GAIN_FRACTION_BITS_DEF = 8;

  // Register reset values
  localparam logic [GAINS_W-1:0] ROLL_GAINS_RST  = 48'h2000_001A_0000; // 32.0 / 0.1 / 0.0
  localparam logic [GAINS_W-1:0] PITCH_GAINS_RST = 48'h1E00_001A_0100; // 30.0 / 0.1 / 1.0
  localparam logic [GAINS_W-1:0] YAW_GAINS_RST   = 48'h1E00_0000_0000; // 30.0 / 0.0 / 0.0
  localparam int OUT_MAX_RST = 28672;   // 28.0 in Q9.10
  localparam int OUT_MIN_RST = -17408;  // -17.0 in Q9.10

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_GAINS  = 3'd0,
    REG_PITCH_GAINS = 3'd1,
    REG_YAW_GAINS   = 3'd2,
    REG_OUTPUT_MAX  = 3'd3,
    REG_OUTPUT_MIN  = 3'd4
  } cfg_reg_e;

  // Pipeline load enables shared by all lanes
  typedef struct packed {
    logic accept;    // request taken into stage 1
    logic ld_s2;     // stage 2 loads
    logic ld_s3;     // stage 3 loads
    logic upd_int;   // a valid request moves into stage 3: integrators step
    logic ld_out;    // output register loads
  } tapid_ctl_t;

endpackage

@@ design/three_axis_attitude_pid.sv @@
// ----------------------------------------------------------------------------
// three_axis_attitude_pid
// Roll, pitch and yaw PID with derivative on measurement, three lanes side
// by side, one shared handshake and one merged output register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in_     | input     | in_valid / in_stall   | measured and target angles
//   out_    | output    | out_valid / out_stall | aileron, elevator, rudder
//   cfg_    | input     | cfg_write_en          | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; out_valid follows the
// accepting edge through the error, multiply, integrator and clamp registers
// (the error register loads at acceptance).
// Synchronous active-low reset clears integrators, last angles, valid bits
// and loads the default gains and limits.
// A stalled output holds the pipeline only as far back as it is full; empty
// stages keep taking requests.
// ----------------------------------------------------------------------------
module three_axis_attitude_pid #(
  parameter int ANGLE_WIDTH        = tapid_pkg::ANGLE_WIDTH_DEF,
  parameter int GAIN_FRACTION_BITS = tapid_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_write_en,
  input  logic [tapid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tapid_pkg::CFG_DATA_W-1:0]   cfg_data,
  // requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ANGLE_WIDTH-1:0]      in_measured_roll,
  input  logic signed [ANGLE_WIDTH-1:0]      in_measured_pitch,
  input  logic signed [ANGLE_WIDTH-1:0]      in_measured_yaw,
  input  logic signed [ANGLE_WIDTH-1:0]      in_target_roll,
  input  logic signed [ANGLE_WIDTH-1:0]      in_target_pitch,
  input  logic signed [ANGLE_WIDTH-1:0]      in_target_yaw,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ANGLE_WIDTH-1:0]      out_aileron_command,
  output logic signed [ANGLE_WIDTH-1:0]      out_elevator_command,
  output logic signed [ANGLE_WIDTH-1:0]      out_rudder_command
);
  import tapid_pkg::*;

  logic [GAINS_W-1:0]            roll_gains_r, pitch_gains_r, yaw_gains_r;
  logic signed [ANGLE_WIDTH-1:0] out_max_r, out_min_r;
  tapid_ctl_t                    ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_gains_r  <= ROLL_GAINS_RST;
      pitch_gains_r <= PITCH_GAINS_RST;
      yaw_gains_r   <= YAW_GAINS_RST;
      out_max_r     <= ANGLE_WIDTH'(OUT_MAX_RST);
      out_min_r     <= ANGLE_WIDTH'(OUT_MIN_RST);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ROLL_GAINS:  roll_gains_r  <= cfg_data[GAINS_W-1:0];
        REG_PITCH_GAINS: pitch_gains_r <= cfg_data[GAINS_W-1:0];
        REG_YAW_GAINS:   yaw_gains_r   <= cfg_data[GAINS_W-1:0];
        REG_OUTPUT_MAX:  out_max_r     <= cfg_data[ANGLE_WIDTH-1:0];
        REG_OUTPUT_MIN:  out_min_r     <= cfg_data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  tapid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Axis lanes
  tapid_lane #(
    .ANGLE_WIDTH        (ANGLE_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .gains    (roll_gains_r),
    .out_max  (out_max_r),
    .out_min  (out_min_r),
    .measured (in_measured_roll),
    .target   (in_target_roll),
    .command  (out_aileron_command)
  );

  tapid_lane #(
    .ANGLE_WIDTH        (ANGLE_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .gains    (pitch_gains_r),
    .out_max  (out_max_r),
    .out_min  (out_min_r),
    .measured (in_measured_pitch),
    .target   (in_target_pitch),
    .command  (out_elevator_command)
  );

  tapid_lane #(
    .ANGLE_WIDTH        (ANGLE_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .gains    (yaw_gains_r),
    .out_max  (out_max_r),
    .out_min  (out_min_r),
    .measured (in_measured_yaw),
    .target   (in_target_yaw),
    .command  (out_rudder_command)
  );

endmodule

@@ design/tapid_ctrl.sv @@
// ----------------------------------------------------------------------------
// tapid_ctrl
// Valid chain and per-stage load enables for the four-stage lane pipeline.
// A stage loads when it is empty or its contents move on, so bubbles close up.
// ----------------------------------------------------------------------------
module tapid_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tapid_pkg::tapid_ctl_t ctl
);
  import tapid_pkg::*;

  logic v1_r, v2_r, v3_r, vo_r;
  logic en1, en2, en3, eno;

  // Load enables, back from the output
  always_comb begin
    eno = !vo_r || !out_stall;
    en3 = !v3_r || eno;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
  end

  assign in_stall  = !en1;
  assign out_valid = vo_r;

  always_comb begin
    ctl.accept  = in_valid && en1;
    ctl.ld_s2   = en2;
    ctl.ld_s3   = en3;
    ctl.upd_int = v2_r && en3;
    ctl.ld_out  = en3 && eno && v3_r;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (eno) vo_r <= v3_r;
    end
  end

endmodule

@@ design/tapid_lane.sv @@
// ----------------------------------------------------------------------------
// tapid_lane
// One axis of the PID: error and change, gain products, integrator step,
// then the clamped command in the output register.
// ----------------------------------------------------------------------------
module tapid_lane #(
  parameter int ANGLE_WIDTH        = tapid_pkg::ANGLE_WIDTH_DEF,
  parameter int GAIN_FRACTION_BITS = tapid_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tapid_pkg::tapid_ctl_t           ctl,
  input  logic [tapid_pkg::GAINS_W-1:0]   gains,
  input  logic signed [ANGLE_WIDTH-1:0]   out_max,
  input  logic signed [ANGLE_WIDTH-1:0]   out_min,
  input  logic signed [ANGLE_WIDTH-1:0]   measured,
  input  logic signed [ANGLE_WIDTH-1:0]   target,
  output logic signed [ANGLE_WIDTH-1:0]   command
);
  import tapid_pkg::*;

  localparam int DW = ANGLE_WIDTH + 1;           // error / change
  localparam int PW = DW + GAIN_W + 1;           // signed gain product
  localparam int W  = ANGLE_WIDTH + GAIN_W + 4;  // sums before clamping

  // Lower bound first, upper bound last
  function automatic logic signed [ANGLE_WIDTH-1:0] clamp(
    input logic signed [W-1:0] v,
    input logic signed [W-1:0] lo,
    input logic signed [W-1:0] hi
  );
    logic signed [W-1:0] t;
    t = v;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return ANGLE_WIDTH'(t);
  endfunction

  logic signed [ANGLE_WIDTH-1:0] last_r;
  logic signed [DW-1:0]          err_r, chg_r;
  logic signed [PW-1:0]          prod_p_r, prod_i_r, prod_d_r;
  logic signed [W-1:0]           pd_r;
  logic signed [ANGLE_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [ANGLE_WIDTH-1:0] cmd_r, cmd_nxt;
  logic signed [W-1:0]           lo_w, hi_w;

  assign lo_w = W'(out_min);
  assign hi_w = W'(out_max);

  // Stage 1: error and change in measurement; remember the angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctl.accept) begin
      last_r <= measured;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      err_r <= DW'(target) - DW'(measured);
      chg_r <= DW'(measured) - DW'(last_r);
    end
  end

  // Stage 2: one multiplier per gain
  always_ff @(posedge clk) begin
    if (ctl.ld_s2) begin
      prod_p_r <= PW'(err_r) * PW'($signed({1'b0, gains[3*GAIN_W-1:2*GAIN_W]}));
      prod_i_r <= PW'(err_r) * PW'($signed({1'b0, gains[2*GAIN_W-1:GAIN_W]}));
      prod_d_r <= PW'(chg_r) * PW'($signed({1'b0, gains[GAIN_W-1:0]}));
    end
  end

  // Stage 3: integrator step and proportional minus derivative
  assign integ_nxt = clamp(W'(integ_r) + W'(prod_i_r >>> GAIN_FRACTION_BITS), lo_w, hi_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (ctl.upd_int) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s3) begin
      pd_r <= W'(prod_p_r >>> GAIN_FRACTION_BITS) - W'(prod_d_r >>> GAIN_FRACTION_BITS);
    end
  end

  // Output: integrator already holds this request's value
  assign cmd_nxt = clamp(pd_r + W'(integ_r), lo_w, hi_w);

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign command = cmd_r;

endmodule

@@ sim/tb_three_axis_attitude_pid.sv @@
// ----------------------------------------------------------------------------
// tb_three_axis_attitude_pid
// Self-checking bench for the three-axis attitude PID. Control ticks go in
// through a bursty driver while the command side stalls on a pattern of its
// own. A built-in predictor keeps its own integrators, last angles, gains
// and limits and queues the expected aileron, elevator and rudder commands.
// The monitor then checks every returned command against the oldest entry.
// Gains and limits change between phases while the block is idle. The phases
// cover full-scale gains, inverted limits, spare register indexes and
// excess data bits.
// ----------------------------------------------------------------------------
module tb_three_axis_attitude_pid;
  timeunit 1ns;
  timeprecision 1ps;

  import tapid_pkg::*;

  localparam int AW          = ANGLE_WIDTH_DEF;
  localparam int GFB         = GAIN_FRACTION_BITS_DEF;
  localparam int NUM_REGS    = 5;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LATENCY_PAD = 8;
  localparam int HOLD_LEN    = 150;
  localparam int HOLD_PERIOD = 1024;
  localparam int HOLD_AT     = 600;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_TICKS = 150;
  localparam int MAX_PRINTS  = 100;

  localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [GAIN_W-1:0]    GAIN_FULL = '1;
  localparam logic [GAIN_W-1:0]    GAIN_NONE = '0;

  typedef enum int {AX_ROLL = 0, AX_PITCH = 1, AX_YAW = 2} axis_e;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  typedef struct packed {
    logic signed [AW-1:0] meas_roll;
    logic signed [AW-1:0] meas_pitch;
    logic signed [AW-1:0] meas_yaw;
    logic signed [AW-1:0] targ_roll;
    logic signed [AW-1:0] targ_pitch;
    logic signed [AW-1:0] targ_yaw;
  } tick_t;

  typedef struct packed {
    logic signed [AW-1:0] aileron;
    logic signed [AW-1:0] elevator;
    logic signed [AW-1:0] rudder;
  } cmd_t;

  // DUT connections
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [AW-1:0]   in_measured_roll = '0;
  logic signed [AW-1:0]   in_measured_pitch = '0;
  logic signed [AW-1:0]   in_measured_yaw = '0;
  logic signed [AW-1:0]   in_target_roll = '0;
  logic signed [AW-1:0]   in_target_pitch = '0;
  logic signed [AW-1:0]   in_target_yaw = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [AW-1:0]   out_aileron_command;
  logic signed [AW-1:0]   out_elevator_command;
  logic signed [AW-1:0]   out_rudder_command;

  // Predictor copy of configuration and state
  logic [GAINS_W-1:0] pid_gains [3];
  longint             lim_hi;
  longint             lim_lo;
  longint             integ_acc [3];
  longint             prev_angle [3];

  // Pending requests, outstanding commands and bookkeeping
  tick_t              tick_queue [$];
  cmd_t               cmd_expected [$];
  int                 mismatch_count = 0;
  logic               req_taken = 1'b0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 rx_cycle = 0;
  int                 hold_left = 0;
  int                 mode_left = 0;
  rx_mode_e           rx_mode = RX_FREE;
  logic signed [AW-1:0] walk_angle [3];

  three_axis_attitude_pid #(
    .ANGLE_WIDTH        (AW),
    .GAIN_FRACTION_BITS (GFB)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_measured_roll     (in_measured_roll),
    .in_measured_pitch    (in_measured_pitch),
    .in_measured_yaw      (in_measured_yaw),
    .in_target_roll       (in_target_roll),
    .in_target_pitch      (in_target_pitch),
    .in_target_yaw        (in_target_yaw),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_aileron_command  (out_aileron_command),
    .out_elevator_command (out_elevator_command),
    .out_rudder_command   (out_rudder_command)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_drive(input longint v);
    // lower bound first, upper bound last: inverted limits give the upper one
    if (v < lim_lo) v = lim_lo;
    if (v > lim_hi) v = lim_hi;
    return v;
  endfunction

  function automatic logic signed [AW-1:0] axis_drive(input axis_e ax,
                                                      input logic signed [AW-1:0] meas_in,
                                                      input logic signed [AW-1:0] targ_in);
    longint meas, targ, kp, ki, kd, err, chg, drive;
    meas = meas_in;
    targ = targ_in;
    kp = longint'(pid_gains[ax][2*GAIN_W +: GAIN_W]);
    ki = longint'(pid_gains[ax][GAIN_W +: GAIN_W]);
    kd = longint'(pid_gains[ax][0 +: GAIN_W]);
    err = targ - meas;
    chg = meas - prev_angle[ax];
    // products are floored by the arithmetic shift
    integ_acc[ax] = clamp_drive(integ_acc[ax] + ((err * ki) >>> GFB));
    drive = ((kp * err) >>> GFB) + integ_acc[ax] - ((kd * chg) >>> GFB);
    prev_angle[ax] = meas;
    drive = clamp_drive(drive);
    return drive[AW-1:0];
  endfunction

  function automatic cmd_t predict_commands(input tick_t t);
    cmd_t c;
    c.aileron  = axis_drive(AX_ROLL,  t.meas_roll,  t.targ_roll);
    c.elevator = axis_drive(AX_PITCH, t.meas_pitch, t.targ_pitch);
    c.rudder   = axis_drive(AX_YAW,   t.meas_yaw,   t.targ_yaw);
    return c;
  endfunction

  task automatic reset_model();
    pid_gains[AX_ROLL]  = ROLL_GAINS_RST;
    pid_gains[AX_PITCH] = PITCH_GAINS_RST;
    pid_gains[AX_YAW]   = YAW_GAINS_RST;
    lim_hi = OUT_MAX_RST;
    lim_lo = OUT_MIN_RST;
    foreach (integ_acc[k]) begin
      integ_acc[k]  = 0;
      prev_angle[k] = 0;
      walk_angle[k] = '0;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [AW-1:0] corner(input int idx);
    case (idx)
      0: return ANG_MAX;
      1: return ANG_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [AW-1:0] random_angle();
    case ($urandom_range(0, 9))
      0: return corner($urandom_range(0, 3));
      1, 2, 3: return AW'($urandom());
      default: return AW'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return GAIN_NONE;
      1: return GAIN_FULL;
      2: return GAIN_W'($urandom());
      default: return GAIN_W'($urandom_range(0, 'h300));
    endcase
  endfunction

  task automatic push_tick(input logic signed [AW-1:0] mr, input logic signed [AW-1:0] mp,
                           input logic signed [AW-1:0] my, input logic signed [AW-1:0] tr,
                           input logic signed [AW-1:0] tp, input logic signed [AW-1:0] ty);
    tick_queue.push_back('{mr, mp, my, tr, tp, ty});
  endtask

  // mostly smooth trajectories that keep the integrators off the rails,
  // the rest anywhere in range
  task automatic push_random_tick();
    logic signed [AW-1:0] tr;
    if ($urandom_range(0, 9) < 6) begin
      foreach (walk_angle[k])
        walk_angle[k] = AW'(walk_angle[k] + (int'($urandom_range(0, 1023)) - 512));
      tr = AW'(walk_angle[AX_ROLL] + (int'($urandom_range(0, 4095)) - 2048));
      push_tick(walk_angle[AX_ROLL], walk_angle[AX_PITCH], walk_angle[AX_YAW], tr,
                AW'(walk_angle[AX_PITCH] + (int'($urandom_range(0, 4095)) - 2048)),
                AW'(walk_angle[AX_YAW] + (int'($urandom_range(0, 4095)) - 2048)));
    end else begin
      push_tick(random_angle(), random_angle(), random_angle(),
                random_angle(), random_angle(), random_angle());
    end
  endtask

  // register write; the predictor copy follows once the edge has passed
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_ROLL_GAINS:  pid_gains[AX_ROLL]  = data;
      REG_PITCH_GAINS: pid_gains[AX_PITCH] = data;
      REG_YAW_GAINS:   pid_gains[AX_YAW]   = data;
      REG_OUTPUT_MAX:  lim_hi = $signed(data[AW-1:0]);
      REG_OUTPUT_MIN:  lim_lo = $signed(data[AW-1:0]);
      default: ;
    endcase
  endtask

  // upper data bits are always junk so that only the low bits may count
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic signed [AW-1:0] val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'({$urandom(), $urandom()});
    data[AW-1:0] = val;
    write_reg(idx, data);
  endtask

  task automatic randomise_config();
    logic signed [AW-1:0] a, b;
    write_reg(REG_ROLL_GAINS,  {random_gain(), random_gain(), random_gain()});
    write_reg(REG_PITCH_GAINS, {random_gain(), random_gain(), random_gain()});
    write_reg(REG_YAW_GAINS,   {random_gain(), random_gain(), random_gain()});
    a = random_angle();
    b = random_angle();
    case ($urandom_range(0, 5))
      0: begin
        write_limit(REG_OUTPUT_MAX, ANG_MAX);
        write_limit(REG_OUTPUT_MIN, ANG_MIN);
      end
      1: begin
        write_limit(REG_OUTPUT_MAX, (a < b) ? a : b);
        write_limit(REG_OUTPUT_MIN, (a < b) ? b : a);
      end
      default: begin
        write_limit(REG_OUTPUT_MAX, (a < b) ? b : a);
        write_limit(REG_OUTPUT_MIN, (a < b) ? a : b);
      end
    endcase
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'({$urandom(), $urandom()}));
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || cmd_expected.size() != 0);
    repeat (LATENCY_PAD) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic signed [AW-1:0] got,
                                 input logic signed [AW-1:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- driver
  // a request stays put until taken; bursts and gaps only between requests
  always @(negedge clk) begin
    tick_t t;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (tick_queue.size() > 0) begin
        t = tick_queue.pop_front();
        in_valid          <= 1'b1;
        in_measured_roll  <= t.meas_roll;
        in_measured_pitch <= t.meas_pitch;
        in_measured_yaw   <= t.meas_yaw;
        in_target_roll    <= t.targ_roll;
        in_target_pitch   <= t.targ_pitch;
        in_target_yaw     <= t.targ_yaw;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // own stall pattern, with a periodic long hold-off to fill the pipeline
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % HOLD_PERIOD == HOLD_AT) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    cmd_t got;
    cmd_t want;
    req_taken <= rst_n && in_valid && !in_stall;
    // check returned commands against the oldest prediction
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_aileron_command, out_elevator_command, out_rudder_command};
      if (cmd_expected.size() == 0) begin
        report_mismatch("command with none outstanding, aileron", got.aileron, '0);
      end else begin
        want = cmd_expected.pop_front();
        if (got.aileron !== want.aileron)
          report_mismatch("aileron", got.aileron, want.aileron);
        if (got.elevator !== want.elevator)
          report_mismatch("elevator", got.elevator, want.elevator);
        if (got.rudder !== want.rudder)
          report_mismatch("rudder", got.rudder, want.rudder);
      end
    end
    // predict on every accepted request
    if (rst_n && in_valid && !in_stall)
      cmd_expected.push_back(predict_commands('{in_measured_roll, in_measured_pitch,
                                                in_measured_yaw, in_target_roll,
                                                in_target_pitch, in_target_yaw}));
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int i, j, ph, idx;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset gains: every pairing of full-scale, zero and minus-one angles
    for (i = 0; i < 4; i++)
      for (j = 0; j < 4; j++)
        push_tick(corner(i), corner(j), corner((i + j) % 4),
                  corner(j), corner(i), corner((i + 1) % 4));
    wait_idle();

    // full-scale gains, widest limits, junk in upper data bits, spare indexes
    write_reg(REG_ROLL_GAINS,  {GAIN_FULL, GAIN_FULL, GAIN_FULL});
    write_reg(REG_PITCH_GAINS, {GAIN_FULL, GAIN_NONE, GAIN_FULL});
    write_reg(REG_YAW_GAINS,   {GAIN_NONE, GAIN_FULL, GAIN_NONE});
    write_limit(REG_OUTPUT_MAX, ANG_MAX);
    write_limit(REG_OUTPUT_MIN, ANG_MIN);
    for (idx = NUM_REGS; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'({$urandom(), $urandom()}));
    for (i = 0; i < 5; i++)
      push_tick(corner(i % 4), corner((i + 1) % 4), corner((i + 2) % 4),
                corner((i + 3) % 4), corner(i % 4), corner((i + 2) % 4));
    wait_idle();

    // inverted limits: everything pins to the upper bound
    write_limit(REG_OUTPUT_MAX, ANG_MIN);
    write_limit(REG_OUTPUT_MIN, ANG_MAX);
    for (i = 0; i < 4; i++)
      push_tick(corner(i), corner(3 - i), corner(i), corner((i + 2) % 4),
                corner(i), corner(3 - i));
    wait_idle();

    // random settings, random ticks
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      randomise_config();
      repeat (PHASE_TICKS) push_random_tick();
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
